@@ hdl/vzc_pkg.sv @@
// vzc_pkg: shared types and constants of the varint/zigzag codec.
// Holds the item, result, configuration and job structs and the status codes.
// No dependencies.
package vzc_pkg;

	localparam logic [3:0] MAX_BYTES_64 = 4'd10;
	localparam logic [3:0] MAX_BYTES_32 = 4'd5;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SMALL     = 3'd1;
	localparam logic [2:0] ST_TRUNC     = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;
	localparam logic [2:0] ST_WIDE      = 3'd5;

	// job kinds in the queue
	localparam logic [1:0] JOB_ENC = 2'd0;  // emit the groups of a value
	localparam logic [1:0] JOB_ERR = 2'd1;  // encoded length above the limit
	localparam logic [1:0] JOB_DEC = 2'd2;  // one decode result

	// configuration register indexes
	localparam logic [1:0] REG_DIRECTION   = 2'd0;
	localparam logic [1:0] REG_WIDTH_MODE  = 2'd1;
	localparam logic [1:0] REG_SIGNED_MODE = 2'd2;
	localparam logic [1:0] REG_OUT_LIMIT   = 2'd3;

	typedef struct packed {
		logic [63:0] value_in;
		logic [7:0]  in_byte;
		logic        input_ends;
	} vzc_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_last;
		logic [63:0] decoded_value;
		logic [2:0]  status;
		logic [3:0]  byte_count;
	} vzc_out_t;

	typedef struct packed {
		logic       direction;
		logic       width_mode;
		logic       signed_mode;
		logic [3:0] out_limit;
	} vzc_cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] value;
		logic [3:0]  count;
		logic [2:0]  status;
	} vzc_job_t;

endpackage

@@ hdl/vzc_front.sv @@
// vzc_front: accepts items, zigzag-maps and sizes values to encode, and runs
// the decode accumulator. Produces one job per result-bearing item.
// Depends on vzc_pkg.
module vzc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  vzc_pkg::vzc_cfg_t  cfg,
	input  logic               item_valid,
	output logic               item_ready,
	input  vzc_pkg::vzc_in_t   item,
	input  logic               q_full,
	output logic               push,
	output vzc_pkg::vzc_job_t  job
);

	logic        accept;
	logic [31:0] v32;
	logic [31:0] zz32;
	logic [63:0] zz64;
	logic [63:0] enc_v;
	logic [3:0]  enc_n;

	logic [63:0] acc_q;
	logic [3:0]  gc_q;
	logic [3:0]  maxb;
	logic [6:0]  payload;
	logic        cont;
	logic [6:0]  shamt;
	logic [63:0] acc_new;
	logic [3:0]  cnt;
	logic [63:0] z;
	logic        dec_res;
	vzc_pkg::vzc_job_t dec_job;

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;

	// encode: zigzag and length
	assign v32  = item.value_in[31:0];
	assign zz32 = cfg.signed_mode ? ({v32[30:0], 1'b0} ^ {32{v32[31]}}) : v32;
	assign zz64 = cfg.signed_mode ?
		({item.value_in[62:0], 1'b0} ^ {64{item.value_in[63]}}) : item.value_in;
	assign enc_v = cfg.width_mode ? zz64 : {32'b0, zz32};

	always_comb begin
		enc_n = 4'd1;
		for (int j = 1; j < 9; j++) begin
			if (|enc_v[7*j +: 7]) begin
				enc_n = 4'(j + 1);
			end
		end
		if (enc_v[63]) begin
			enc_n = 4'd10;
		end
	end

	// decode: one byte per item
	assign maxb    = cfg.width_mode ? vzc_pkg::MAX_BYTES_64 : vzc_pkg::MAX_BYTES_32;
	assign payload = item.in_byte[6:0];
	assign cont    = item.in_byte[7];
	assign shamt   = {gc_q, 3'b000} - {3'b000, gc_q};
	assign acc_new = acc_q | ({57'b0, payload} << shamt);
	assign cnt     = gc_q + 4'd1;

	always_comb begin
		if (cfg.width_mode) begin
			z = cfg.signed_mode ? ((acc_new >> 1) ^ {64{acc_new[0]}}) : acc_new;
		end else begin
			z = cfg.signed_mode ?
				{32'b0, (acc_new[31:0] >> 1) ^ {32{acc_new[0]}}} :
				{32'b0, acc_new[31:0]};
		end
	end

	always_comb begin
		dec_res        = 1'b1;
		dec_job.kind   = vzc_pkg::JOB_DEC;
		dec_job.value  = 64'b0;
		dec_job.count  = cnt;
		dec_job.status = vzc_pkg::ST_OK;
		if (gc_q >= maxb) begin
			// held more bytes than the current width allows
			dec_job.status = vzc_pkg::ST_MALFORMED;
			dec_job.count  = (cnt > vzc_pkg::MAX_BYTES_64) ? vzc_pkg::MAX_BYTES_64 : cnt;
		end else if (cnt == vzc_pkg::MAX_BYTES_64 &&
				(payload > 7'd1 || (cont && payload != 7'd0))) begin
			dec_job.status = vzc_pkg::ST_OVERFLOW;
		end else if (!cont) begin
			if (!cfg.width_mode && (|acc_new[63:32])) begin
				dec_job.status = vzc_pkg::ST_WIDE;
			end else begin
				dec_job.value = z;
			end
		end else if (cnt >= maxb) begin
			dec_job.status = vzc_pkg::ST_MALFORMED;
		end else if (item.input_ends) begin
			dec_job.status = vzc_pkg::ST_TRUNC;
		end else begin
			dec_res = 1'b0;
		end
	end

	always_comb begin
		if (cfg.direction) begin
			push = accept && dec_res;
			job  = dec_job;
		end else begin
			push       = accept;
			job.kind   = (enc_n > cfg.out_limit) ? vzc_pkg::JOB_ERR : vzc_pkg::JOB_ENC;
			job.value  = enc_v;
			job.count  = enc_n;
			job.status = (enc_n > cfg.out_limit) ? vzc_pkg::ST_SMALL : vzc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 64'b0;
			gc_q  <= 4'd0;
		end else if (accept && cfg.direction) begin
			if (dec_res) begin
				acc_q <= 64'b0;
				gc_q  <= 4'd0;
			end else begin
				acc_q <= acc_new;
				gc_q  <= cnt;
			end
		end
	end

endmodule

@@ hdl/vzc_queue.sv @@
// vzc_queue: small register FIFO of jobs between front and back.
// Depends on vzc_pkg.
module vzc_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  vzc_pkg::vzc_job_t  push_job,
	output logic               full,
	input  logic               pop,
	output vzc_pkg::vzc_job_t  head,
	output logic               empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	vzc_pkg::vzc_job_t slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
		else $error("job pushed into a full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("job popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("queue count above depth");
`endif

endmodule

@@ hdl/vzc_back.sv @@
// vzc_back: drains jobs into result words, one encoded byte per cycle while
// result_ready is high, through a registered output stage. Depends on vzc_pkg.
module vzc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  vzc_pkg::vzc_job_t  head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output vzc_pkg::vzc_out_t  result
);

	logic              out_valid_q;
	vzc_pkg::vzc_out_t out_q;
	logic              active_q;
	logic [63:0]       sh_q;
	logic [3:0]        rem_q;
	logic [3:0]        cnt_q;

	logic              adv;
	logic              load;
	vzc_pkg::vzc_out_t out_d;
	logic              active_d;
	logic [63:0]       sh_d;
	logic [3:0]        rem_d;
	logic [3:0]        cnt_d;

	function automatic vzc_pkg::vzc_out_t enc_word(logic [63:0] v, logic [3:0] rem,
			logic [3:0] n);
		vzc_pkg::vzc_out_t w;
		w.out_byte      = {rem != 4'd1, v[6:0]};
		w.out_last      = rem == 4'd1;
		w.decoded_value = 64'b0;
		w.status        = vzc_pkg::ST_OK;
		w.byte_count    = n;
		return w;
	endfunction

	assign adv          = !out_valid_q || result_ready;
	assign pop          = adv && !active_q && !q_empty;
	assign load         = adv && (active_q || !q_empty);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		out_d    = enc_word(sh_q, rem_q, cnt_q);
		active_d = rem_q != 4'd1;
		sh_d     = sh_q >> 7;
		rem_d    = rem_q - 4'd1;
		cnt_d    = cnt_q;
		if (!active_q) begin
			cnt_d = head.count;
			sh_d  = head.value >> 7;
			rem_d = head.count - 4'd1;
			case (head.kind)
				vzc_pkg::JOB_ENC: begin
					out_d    = enc_word(head.value, head.count, head.count);
					active_d = head.count != 4'd1;
				end
				vzc_pkg::JOB_ERR: begin
					out_d.out_byte      = 8'b0;
					out_d.out_last      = 1'b1;
					out_d.decoded_value = 64'b0;
					out_d.status        = head.status;
					out_d.byte_count    = 4'd0;
					active_d            = 1'b0;
				end
				default: begin
					out_d.out_byte      = 8'b0;
					out_d.out_last      = 1'b0;
					out_d.decoded_value = head.value;
					out_d.status        = head.status;
					out_d.byte_count    = head.count;
					active_d            = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_d;
			sh_q  <= sh_d;
			rem_q <= rem_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
		end else if (adv) begin
			out_valid_q <= load;
			active_q    <= load && active_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_active_shown: assert property (@(posedge clk) disable iff (!arst_n)
			active_q |-> out_valid_q)
		else $error("encode in progress without a pending output word");
	a_active_rem: assert property (@(posedge clk) disable iff (!arst_n)
			active_q |-> (rem_q != 4'd0 && !out_q.out_last))
		else $error("encode in progress with no bytes left");
`endif

endmodule

@@ hdl/varint_zigzag_codec.sv @@
// varint_zigzag_codec: top level of the LEB128 varint codec with zigzag mapping.
// Instantiates vzc_front, vzc_queue and vzc_back; depends on vzc_pkg.
//
// The codec runs in one of two directions set through the configuration port.
// Encoding takes one 32- or 64-bit value per item (zigzag-mapped when
// signed_mode is 1) and returns its 7-bit groups, low group first, one byte per
// result word with out_last on the final byte; a value longer than out_limit
// bytes returns one word with status 1 instead. Decoding takes one byte per
// item and returns one word when a value completes or an error is found
// (truncated, overflow, malformed, exceeds 32 bits); the accumulator clears
// after every such word. Rate: a decode byte is taken every cycle unless the
// queue is full; an encoded value holds the output for one word per byte, so
// the single-byte output register sets the encode rate. An accepted item is
// registered in the queue and then in the output register. A queue of
// QUEUE_DEPTH jobs sits between the front (classification, zigzag,
// accumulator) and the back (byte serializer), so input keeps flowing while
// results wait. Write configuration only while idle; writes are always taken.
module varint_zigzag_codec #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  vzc_pkg::vzc_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output vzc_pkg::vzc_out_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data
);

	vzc_pkg::vzc_cfg_t cfg_q;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	vzc_pkg::vzc_job_t job;
	vzc_pkg::vzc_job_t head;

	// configuration registers: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction   <= 1'b0;
			cfg_q.width_mode  <= 1'b1;
			cfg_q.signed_mode <= 1'b0;
			cfg_q.out_limit   <= vzc_pkg::MAX_BYTES_64;
		end else if (cfg_valid) begin
			case (cfg_index)
				vzc_pkg::REG_DIRECTION:   cfg_q.direction   <= cfg_data[0];
				vzc_pkg::REG_WIDTH_MODE:  cfg_q.width_mode  <= cfg_data[0];
				vzc_pkg::REG_SIGNED_MODE: cfg_q.signed_mode <= cfg_data[0];
				vzc_pkg::REG_OUT_LIMIT:   cfg_q.out_limit   <= cfg_data;
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	// front: accept and classify
	vzc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.job        (job)
	);

	// hold jobs between the two sides
	vzc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// back: serialize into result words
	vzc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("front pushed a job into a full queue");
	a_last_has_count: assert property (@(posedge clk) disable iff (!arst_n)
			(result_valid && result.out_last && result.status == vzc_pkg::ST_OK)
			|-> result.byte_count != 4'd0)
		else $error("final encoded byte without a byte count");
	a_pop_feeds_output: assert property (@(posedge clk) disable iff (!arst_n)
			pop |=> result_valid)
		else $error("popped job produced no result word");
`endif

endmodule

@@ sim/vzc_ledger_pkg.sv @@
// vzc_ledger_pkg: expected-word ledger for the varint/zigzag codec testbench.
// Predicts result words from accepted input words and checks them in order.
// Depends on vzc_pkg for the word structs, status codes and register indexes.
package vzc_ledger_pkg;

	import vzc_pkg::*;

	class varint_ledger;
		bit          direction;
		bit          width_mode;
		bit          signed_mode;
		bit [3:0]    out_limit;
		bit [63:0]   acc;
		bit [3:0]    groups;
		vzc_out_t    due_words[$];
		int unsigned errors;

		function new();
			direction   = 1'b0;
			width_mode  = 1'b1;
			signed_mode = 1'b0;
			out_limit   = 4'd10;
			acc         = '0;
			groups      = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [1:0] index, logic [3:0] data);
			case (index)
				REG_DIRECTION:   direction   = data[0];
				REG_WIDTH_MODE:  width_mode  = data[0];
				REG_SIGNED_MODE: signed_mode = data[0];
				REG_OUT_LIMIT:   out_limit   = data;
				default: ;
			endcase
		endfunction

		function int waiting();
			return due_words.size();
		endfunction

		function void push_word(bit [7:0] b, bit last, bit [63:0] value, bit [2:0] st,
				bit [3:0] cnt);
			vzc_out_t w;
			w.out_byte      = b;
			w.out_last      = last;
			w.decoded_value = value;
			w.status        = st;
			w.byte_count    = cnt;
			due_words.push_back(w);
		endfunction

		// one decode word ends the value: clear the accumulator
		function void close_value(bit [63:0] value, bit [2:0] st, int cnt);
			push_word(8'h00, 1'b0, value, st, cnt[3:0]);
			acc    = '0;
			groups = '0;
		endfunction

		function void encode_value(bit [63:0] raw);
			bit [63:0] v;
			bit [63:0] t;
			bit [31:0] lo;
			int n;
			int k;
			v = raw;
			if (!width_mode) begin
				lo = raw[31:0];
				if (signed_mode)
					lo = (lo << 1) ^ {32{raw[31]}};
				v = {32'b0, lo};
			end else if (signed_mode) begin
				v = (raw << 1) ^ {64{raw[63]}};
			end
			n = 0;
			t = v;
			do begin
				n++;
				t = t >> 7;
			end while (t != 0);
			if (n > out_limit) begin
				push_word(8'h00, 1'b1, '0, ST_SMALL, 4'd0);
				return;
			end
			for (k = 0; k < n; k++) begin
				push_word({(v >> 7) != 0, v[6:0]}, k == n - 1, '0, ST_OK, n[3:0]);
				v = v >> 7;
			end
		endfunction

		function void decode_byte(vzc_in_t it);
			bit [63:0] z;
			bit [6:0]  payload;
			bit        cont;
			int        i;
			int        cnt;
			int        maxb;
			payload = it.in_byte[6:0];
			cont    = it.in_byte[7];
			i       = int'(groups);
			maxb    = int'(width_mode ? MAX_BYTES_64 : MAX_BYTES_32);
			// more bytes held than the current width allows
			if (i >= maxb) begin
				close_value('0, ST_MALFORMED, (i + 1 > 10) ? 10 : i + 1);
				return;
			end
			acc    = acc | ({57'b0, payload} << (7 * i));
			cnt    = i + 1;
			groups = cnt[3:0];
			if (cnt == 10 && (payload > 1 || (cont && payload != 0))) begin
				close_value('0, ST_OVERFLOW, cnt);
				return;
			end
			if (!cont) begin
				z = acc;
				if (!width_mode) begin
					if (z[63:32] != 0) begin
						close_value('0, ST_WIDE, cnt);
						return;
					end
					if (signed_mode)
						z = {32'b0, (z[31:0] >> 1) ^ {32{z[0]}}};
				end else if (signed_mode) begin
					z = (z >> 1) ^ {64{z[0]}};
				end
				close_value(z, ST_OK, cnt);
				return;
			end
			if (cnt >= maxb)
				close_value('0, ST_MALFORMED, cnt);
			else if (it.input_ends)
				close_value('0, ST_TRUNC, cnt);
		endfunction

		function void take_item(vzc_in_t it);
			if (direction)
				decode_byte(it);
			else
				encode_value(it.value_in);
		endfunction

		function void compare_field(string name, bit [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_word(vzc_out_t got);
			vzc_out_t want;
			if (due_words.size() == 0) begin
				$error("result word 0x%0h arrived with nothing expected", got);
				errors++;
				return;
			end
			want = due_words.pop_front();
			compare_field("out_byte", want.out_byte, got.out_byte);
			compare_field("out_last", want.out_last, got.out_last);
			compare_field("decoded_value", want.decoded_value, got.decoded_value);
			compare_field("status", want.status, got.status);
			compare_field("byte_count", want.byte_count, got.byte_count);
		endfunction
	endclass

endpackage

@@ sim/varint_zigzag_codec_test.sv @@
// varint_zigzag_codec_test: self-checking testbench of the varint/zigzag codec.
// Drives directed and random words through varint_zigzag_codec and checks results.
// Depends on vzc_pkg and vzc_ledger_pkg.
module varint_zigzag_codec_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vzc_pkg::*;
	import vzc_ledger_pkg::*;

	localparam int STALL_LIMIT  = 1000;  // cycles with no handshake at all
	localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
	localparam int DRAIN_CYCLES = 8;     // covers the queue and output registers with margin
	localparam int PHASE_ITEMS  = 42;

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_ready;
	vzc_in_t  item;
	logic     result_valid;
	logic     result_ready;
	vzc_out_t result;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [1:0] cfg_index;
	logic [3:0] cfg_data;

	// idling knobs, in percent of cycles
	int gap_pct   = 0;
	int stall_pct = 0;
	bit hold_req  = 1'b0;

	varint_ledger ledger = new();

	varint_zigzag_codec u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: drive ready at the falling edge. A hold request drops ready for a
	// long stretch so the queue fills and the codec stalls its input.
	initial begin : receiver
		int hold_left;
		hold_left    = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Check every result word taken at a rising edge against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			ledger.check_word(result);
	end

	// Watchdog: end the run if no word moves on any channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("varint_zigzag_codec: mismatch");
		$finish;
	end

	function automatic vzc_in_t codec_item(logic [63:0] value, logic [7:0] b, logic ends);
		vzc_in_t it;
		it.value_in   = value;
		it.in_byte    = b;
		it.input_ends = ends;
		return it;
	endfunction

	// Spread value lengths: full width, short positives and short negatives.
	function automatic logic [63:0] random_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(3))
			0: v = v >> $urandom_range(63);
			1: v = ~(v >> $urandom_range(63));
			default: ;
		endcase
		return v;
	endfunction

	// Offer one input word, after a random gap, and hold it until accepted.
	// Entered and left at a falling edge.
	task automatic send_item(vzc_in_t it);
		while ($urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		ledger.take_item(it);
		@(negedge clk);
	endtask

	// Write one register once the codec is idle: drop valid, wait for every
	// expected word, then give the pipeline a few quiet cycles to settle.
	task automatic write_reg(logic [1:0] index, logic [3:0] data);
		item_valid <= 1'b0;
		while (ledger.waiting() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_index <= index;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_reg(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One decode byte run: mostly well-formed values with random groups, the
	// rest cut short, too long, or plain noise.
	task automatic send_byte_run(inout int sent);
		vzc_in_t    run[$];
		int         maxb;
		int         len;
		int         pick;
		int         k;
		logic [6:0] payload;
		maxb = int'(ledger.width_mode ? MAX_BYTES_64 : MAX_BYTES_32);
		pick = $urandom_range(99);
		if (pick < 70) begin
			// favor the full length now and then; keep most ten-byte tails legal
			len = ($urandom_range(3) == 0) ? maxb : $urandom_range(maxb, 1);
			for (k = 0; k < len; k++) begin
				payload = 7'($urandom);
				if (k == len - 1 && len == 10 && $urandom_range(3) != 0)
					payload = 7'($urandom_range(1));
				run.push_back(codec_item(random_value(), {k != len - 1, payload},
						(k == len - 1) ? 1'($urandom_range(1)) : 1'b0));
			end
		end else if (pick < 80) begin
			// truncated: a continuation byte flagged as end of input
			len = $urandom_range(maxb - 1, 1);
			for (k = 0; k < len; k++)
				run.push_back(codec_item(random_value(), {1'b1, 7'($urandom)}, k == len - 1));
		end else if (pick < 90) begin
			// never terminates within the byte limit
			for (k = 0; k < maxb; k++) begin
				payload = (k == maxb - 1 && $urandom_range(1)) ? 7'd0 : 7'($urandom);
				run.push_back(codec_item(random_value(), {1'b1, payload}, 1'b0));
			end
		end else begin
			len = $urandom_range(4, 1);
			for (k = 0; k < len; k++)
				run.push_back(codec_item(random_value(), 8'($urandom),
						$urandom_range(3) == 0));
		end
		foreach (run[j])
			send_item(run[j]);
		sent += run.size();
	endtask

	// One random phase: write every register, set the idling, then stream words.
	task automatic run_phase(logic dir, logic wid, logic sgn, logic [3:0] lim, int gap,
			int stall, bit squeeze);
		int sent;
		write_reg(REG_DIRECTION, {3'b000, dir});
		write_reg(REG_WIDTH_MODE, {3'b000, wid});
		write_reg(REG_SIGNED_MODE, {3'b000, sgn});
		write_reg(REG_OUT_LIMIT, lim);
		gap_pct   = gap;
		stall_pct = stall;
		sent      = 0;
		while (sent < PHASE_ITEMS) begin
			if (squeeze && sent == 12)
				hold_req = 1'b1;
			if (dir) begin
				send_byte_run(sent);
			end else begin
				send_item(codec_item(random_value(), 8'($urandom), 1'($urandom)));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Encode extremes at reset settings: 64-bit, unsigned, limit 10.
		send_item(codec_item(64'd0, 8'h00, 1'b0));
		send_item(codec_item(64'd128, 8'hFF, 1'b1));
		send_item(codec_item('1, 8'h00, 1'b0));
		// Zigzag: most negative maps to all ones, minus one maps to one.
		write_reg(REG_SIGNED_MODE, 4'd1);
		send_item(codec_item(64'h8000_0000_0000_0000, 8'hFF, 1'b1));
		send_item(codec_item('1, 8'h00, 1'b0));
		// 32-bit signed: upper half ignored, most negative gives five bytes.
		write_reg(REG_WIDTH_MODE, 4'd0);
		send_item(codec_item(64'hDEAD_BEEF_8000_0000, 8'h55, 1'b0));
		// Limit zero refuses even a single byte; limit one refuses two bytes.
		write_reg(REG_OUT_LIMIT, 4'd0);
		send_item(codec_item(64'd0, 8'hAA, 1'b1));
		write_reg(REG_OUT_LIMIT, 4'd1);
		send_item(codec_item(64'd200, 8'h00, 1'b0));

		// Decode, 64-bit unsigned.
		write_reg(REG_DIRECTION, 4'd1);
		write_reg(REG_WIDTH_MODE, 4'd1);
		write_reg(REG_SIGNED_MODE, 4'd0);
		// Hold two groups, encode a value in between, then finish the value:
		// encoding must leave the partial decode alone.
		send_item(codec_item(random_value(), 8'h81, 1'b0));
		send_item(codec_item(random_value(), 8'h82, 1'b0));
		write_reg(REG_DIRECTION, 4'd0);
		send_item(codec_item(64'h1234, 8'h00, 1'b1));
		write_reg(REG_DIRECTION, 4'd1);
		send_item(codec_item(random_value(), 8'h03, 1'b1));
		// Truncated: continuation byte marked as end of input.
		send_item(codec_item(random_value(), 8'h85, 1'b1));
		// Hold six groups, then narrow to 32-bit: the next byte is malformed.
		repeat (6) send_item(codec_item(random_value(), 8'h80, 1'b0));
		write_reg(REG_WIDTH_MODE, 4'd0);
		send_item(codec_item(random_value(), 8'h00, 1'b0));
		// Five groups that complete above 32 bits.
		repeat (4) send_item(codec_item(random_value(), 8'hFF, 1'b0));
		send_item(codec_item(random_value(), 8'h1F, 1'b0));

		// Random phases: no idling, sender gaps, receiver stalls, both light.
		run_phase(1'b0, 1'b1, 1'b0, 4'd10, 0, 0, 1'b1);
		run_phase(1'b1, 1'b1, 1'b0, 4'd10, 52, 0, 1'b0);
		run_phase(1'b0, 1'b0, 1'b1, 4'd3, 0, 52, 1'b0);
		run_phase(1'b1, 1'b0, 1'b1, 4'd10, 7, 7, 1'b0);
		run_phase(1'b1, 1'b1, 1'b1, 4'd15, 0, 0, 1'b0);
		run_phase(1'b0, 1'b0, 1'b0, 4'd5, 52, 0, 1'b0);
		run_phase(1'b1, 1'b0, 1'b0, 4'd1, 0, 52, 1'b0);
		run_phase(1'b0, 1'b1, 1'b1, 4'd15, 7, 7, 1'b0);

		// Drain: wait for every expected word, then a few more cycles so a
		// stray extra word would still be caught.
		item_valid <= 1'b0;
		while (ledger.waiting() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (ledger.errors == 0)
			$display("varint_zigzag_codec: match");
		else
			$display("varint_zigzag_codec: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
hdl/vzc_pkg.sv
hdl/vzc_front.sv
hdl/vzc_queue.sv
hdl/vzc_back.sv
hdl/varint_zigzag_codec.sv
sim/vzc_ledger_pkg.sv
sim/varint_zigzag_codec_test.sv
